>>> src/scfb_pkg.sv
// package for the servo command frame builder
// holds packet constants, limit tables, clamp helper and shared types
// no dependencies
package scfb_pkg;

  // command codes
  localparam logic FUNC_POSITION = 1'b0;
  localparam logic FUNC_TORQUE   = 1'b1;

  // packet constants
  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] POS_LEN     = 8'd9;
  localparam logic [7:0] TRQ_LEN     = 8'd4;
  localparam logic [7:0] WRITE_INSTR = 8'd3;
  localparam logic [7:0] POS_REG     = 8'd42;
  localparam logic [7:0] TRQ_REG     = 8'd40;
  localparam logic [9:0] POS_FULL_MAX = 10'd1023;
  localparam int unsigned NUM_LIMITED = 8;

  // byte slots within a packet
  localparam int unsigned SLOT_W = 4;
  localparam logic [SLOT_W-1:0] SLOT_HDR0    = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_HDR1    = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_ID      = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_LEN     = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_INSTR   = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_REG     = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_DATA0   = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_DATA1   = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_TIME_HI = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_TIME_LO = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_PAD0    = 4'd10;
  localparam logic [SLOT_W-1:0] SLOT_PAD1    = 4'd11;
  localparam logic [SLOT_W-1:0] SLOT_POS_CHK = 4'd12;
  localparam logic [SLOT_W-1:0] SLOT_TRQ_CHK = 4'd7;

  // registered command
  typedef struct packed {
    logic               func;
    logic [7:0]         servo_id;
    logic signed [15:0] position;
    logic [15:0]        move_time;
    logic               torque_on;
  } cmd_t;

  // built frame, everything the serializer needs
  typedef struct packed {
    logic        func;
    logic [7:0]  servo_id;
    logic [9:0]  pos_val;
    logic [15:0] move_time;
    logic        torque_on;
    logic [7:0]  chk;
  } frame_t;

  // per-servo lower limits
  function automatic logic [9:0] lim_lo(input logic [2:0] idx);
    logic [9:0] r;
    case (idx)
      3'd0:    r = 10'd276;
      3'd1:    r = 10'd536;
      3'd2:    r = 10'd791;
      3'd3:    r = 10'd36;
      3'd4:    r = 10'd326;
      3'd5:    r = 10'd471;
      3'd6:    r = 10'd821;
      default: r = 10'd66;
    endcase
    return r;
  endfunction

  // per-servo upper limits
  function automatic logic [9:0] lim_hi(input logic [2:0] idx);
    logic [9:0] r;
    case (idx)
      3'd0:    r = 10'd476;
      3'd1:    r = 10'd736;
      3'd2:    r = 10'd991;
      3'd3:    r = 10'd236;
      3'd4:    r = 10'd526;
      3'd5:    r = 10'd671;
      3'd6:    r = 10'd1023;
      default: r = 10'd266;
    endcase
    return r;
  endfunction

  // clamp a signed value to a window of non-negative bounds
  function automatic logic signed [15:0] clamp_pos(input logic signed [15:0] v,
                                                   input logic [9:0] lo,
                                                   input logic [9:0] hi);
    logic signed [15:0] lo_s;
    logic signed [15:0] hi_s;
    logic signed [15:0] r;
    lo_s = signed'({6'd0, lo});
    hi_s = signed'({6'd0, hi});
    if (v < lo_s) begin
      r = lo_s;
    end else if (v > hi_s) begin
      r = hi_s;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> src/scfb_frame_build.sv
// frame builder: clamps the goal position and computes the packet checksum
// depends on scfb_pkg
module scfb_frame_build import scfb_pkg::*; (
  input  cmd_t   cmd_i,
  output frame_t frame_o
);

  logic signed [15:0] win_pos;
  logic signed [15:0] full_pos;
  logic [9:0]         pos_val;
  logic [7:0]         sum_pos;
  logic [7:0]         sum_trq;

  // per-servo window, then the full range
  always_comb begin
    if (cmd_i.servo_id < 8'(NUM_LIMITED)) begin
      win_pos = clamp_pos(cmd_i.position, lim_lo(cmd_i.servo_id[2:0]),
                          lim_hi(cmd_i.servo_id[2:0]));
    end else begin
      win_pos = cmd_i.position;
    end
    full_pos = clamp_pos(win_pos, 10'd0, POS_FULL_MAX);
    pos_val  = full_pos[9:0];
  end

  // 8-bit sums from the id onward
  always_comb begin
    sum_pos = cmd_i.servo_id + POS_LEN + WRITE_INSTR + POS_REG
            + {6'd0, pos_val[9:8]} + pos_val[7:0]
            + cmd_i.move_time[15:8] + cmd_i.move_time[7:0];
    sum_trq = cmd_i.servo_id + TRQ_LEN + WRITE_INSTR + TRQ_REG
            + {7'd0, cmd_i.torque_on};
  end

  // frame fields
  always_comb begin
    frame_o.func      = cmd_i.func;
    frame_o.servo_id  = cmd_i.servo_id;
    frame_o.pos_val   = pos_val;
    frame_o.move_time = cmd_i.move_time;
    frame_o.torque_on = cmd_i.torque_on;
    frame_o.chk       = (cmd_i.func == FUNC_TORQUE) ? ~sum_trq : ~sum_pos;
  end

endmodule

>>> src/scfb_serializer.sv
// serializer: holds one built frame and sends it one byte per transaction
// depends on scfb_pkg
module scfb_serializer import scfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  frame_t     frame_i,
  output logic       busy_o,
  output logic       done_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       last_byte_o
);

  logic              vld_q, vld_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  frame_t            frame_q;
  logic [SLOT_W-1:0] last_idx;
  logic              out_acc;

  assign last_idx    = (frame_q.func == FUNC_TORQUE) ? SLOT_TRQ_CHK : SLOT_POS_CHK;
  assign out_valid_o = vld_q;
  assign out_acc     = vld_q && !out_stall_i;
  assign last_byte_o = (idx_q == last_idx);
  assign done_o      = out_acc && last_byte_o;
  assign busy_o      = vld_q;

  // byte select
  always_comb begin
    case (idx_q)
      SLOT_HDR0, SLOT_HDR1: tx_byte_o = HDR_BYTE;
      SLOT_ID:              tx_byte_o = frame_q.servo_id;
      SLOT_LEN:             tx_byte_o = (frame_q.func == FUNC_TORQUE) ? TRQ_LEN : POS_LEN;
      SLOT_INSTR:           tx_byte_o = WRITE_INSTR;
      SLOT_REG:             tx_byte_o = (frame_q.func == FUNC_TORQUE) ? TRQ_REG : POS_REG;
      SLOT_DATA0:           tx_byte_o = (frame_q.func == FUNC_TORQUE) ?
                                        {7'd0, frame_q.torque_on} :
                                        {6'd0, frame_q.pos_val[9:8]};
      SLOT_DATA1:           tx_byte_o = (frame_q.func == FUNC_TORQUE) ? frame_q.chk :
                                        frame_q.pos_val[7:0];
      SLOT_TIME_HI:         tx_byte_o = frame_q.move_time[15:8];
      SLOT_TIME_LO:         tx_byte_o = frame_q.move_time[7:0];
      SLOT_PAD0, SLOT_PAD1: tx_byte_o = 8'h00;
      SLOT_POS_CHK:         tx_byte_o = frame_q.chk;
      default:              tx_byte_o = 8'h00;
    endcase
  end

  // byte counter and frame valid
  always_comb begin
    vld_d = vld_q;
    idx_d = idx_q;
    if (load_i) begin
      vld_d = 1'b1;
      idx_d = SLOT_HDR0;
    end else if (done_o) begin
      vld_d = 1'b0;
      idx_d = SLOT_HDR0;
    end else if (out_acc) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= SLOT_HDR0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  // frame storage
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> idx_q <= last_idx)
    else $error("byte index past end of packet");

  a_load_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> vld_q && idx_q == SLOT_HDR0)
    else $error("frame load did not restart at header");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !vld_q || done_o)
    else $error("frame overwritten while still sending");

  a_done_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !load_i |=> !vld_q)
    else $error("serializer still valid after last byte");
`endif

endmodule

>>> src/servo_command_frame_builder_core.sv
// servo command frame builder, top level
// depends on scfb_pkg, scfb_frame_build, scfb_serializer
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one servo command per
//   transaction: func_i selects goal position (0) or torque enable (1).
//   Output channel (out_valid_o / out_stall_i) sends the write packet one
//   byte per transaction; last_byte_o marks the checksum byte.
//   A position command gives 13 bytes, a torque command gives 8 bytes.
//   An accepted command is first registered in the command register; its
//   frame is then loaded into the serializer when the output is free, and
//   the first byte is valid after that load. The serializer sends one byte
//   per cycle while the receiver does not stall. A command register in
//   front holds the next command while the current packet drains, and its
//   frame is loaded in the cycle the last byte goes out, so packets follow
//   with no gap.
//   Reset clears the command and frame valid flags; nothing is sent.
//   When the receiver stalls, the current byte holds; once the command
//   register is full, in_stall_o rises until the packet completes.
module servo_command_frame_builder_core import scfb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [7:0]         servo_id_i,
  input  logic signed [15:0] position_i,
  input  logic [15:0]        move_time_i,
  input  logic               torque_on_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         tx_byte_o,
  output logic               last_byte_o
);

  logic   cmd_vld_q, cmd_vld_d;
  cmd_t   cmd_q;
  frame_t frame;
  logic   ser_busy;
  logic   ser_done;
  logic   frame_load;
  logic   in_acc;

  // handshake
  assign frame_load = cmd_vld_q && (!ser_busy || ser_done);
  assign in_stall_o = cmd_vld_q && !frame_load;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cmd_vld_d  = in_acc || (cmd_vld_q && !frame_load);

  // command register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else begin
      cmd_vld_q <= cmd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q.func      <= func_i;
      cmd_q.servo_id  <= servo_id_i;
      cmd_q.position  <= position_i;
      cmd_q.move_time <= move_time_i;
      cmd_q.torque_on <= torque_on_i;
    end
  end

  // clamp and checksum
  scfb_frame_build u_build (
    .cmd_i   (cmd_q),
    .frame_o (frame)
  );

  // byte output
  scfb_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (frame_load),
    .frame_i     (frame),
    .busy_o      (ser_busy),
    .done_o      (ser_done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

>>> verif/servo_command_frame_builder_core_test.sv
// testbench for servo_command_frame_builder_core: drives servo commands, checks packet bytes
// predicts each write packet on its own and compares every byte and the last flag
// depends on scfb_pkg and the servo_command_frame_builder_core rtl
`timescale 1ns / 1ps

module servo_command_frame_builder_core_test;
  import scfb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } packet_byte_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               func_i;
  logic [7:0]         servo_id_i;
  logic signed [15:0] position_i;
  logic [15:0]        move_time_i;
  logic               torque_on_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         tx_byte_o;
  logic               last_byte_o;

  packet_byte_t expected_bytes[$];
  int           mismatch_count;
  int           bytes_checked;
  int           pos_cmds_sent;
  int           trq_cmds_sent;
  int           cycle_count;
  int           stall_left;
  bit           sender_idles;
  bit           receiver_stalls;

  servo_command_frame_builder_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .servo_id_i  (servo_id_i),
    .position_i  (position_i),
    .move_time_i (move_time_i),
    .torque_on_i (torque_on_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // per-servo position window, ids 0 to 7
  function automatic int window_min(input logic [2:0] idx);
    case (idx)
      3'd0:    return 276;
      3'd1:    return 536;
      3'd2:    return 791;
      3'd3:    return 36;
      3'd4:    return 326;
      3'd5:    return 471;
      3'd6:    return 821;
      default: return 66;
    endcase
  endfunction

  function automatic int window_max(input logic [2:0] idx);
    case (idx)
      3'd0:    return 476;
      3'd1:    return 736;
      3'd2:    return 991;
      3'd3:    return 236;
      3'd4:    return 526;
      3'd5:    return 671;
      3'd6:    return 1023;
      default: return 266;
    endcase
  endfunction

  // build the expected write packet for one command and queue its bytes
  function automatic void build_write_packet(input logic f, input logic [7:0] id,
                                             input logic signed [15:0] pos,
                                             input logic [15:0] ms, input logic en);
    logic [7:0]   pkt [0:12];
    logic [7:0]   sum;
    int           n;
    int           goal;
    packet_byte_t b;
    pkt[0] = HDR_BYTE;
    pkt[1] = HDR_BYTE;
    pkt[2] = id;
    if (f == FUNC_POSITION) begin
      goal = int'(pos);
      // limited servos get their own window first
      if (id < NUM_LIMITED) begin
        if (goal < window_min(id[2:0])) goal = window_min(id[2:0]);
        if (goal > window_max(id[2:0])) goal = window_max(id[2:0]);
      end
      if (goal < 0) goal = 0;
      if (goal > int'(POS_FULL_MAX)) goal = int'(POS_FULL_MAX);
      pkt[3]  = POS_LEN;
      pkt[4]  = WRITE_INSTR;
      pkt[5]  = POS_REG;
      pkt[6]  = goal[15:8];
      pkt[7]  = goal[7:0];
      pkt[8]  = ms[15:8];
      pkt[9]  = ms[7:0];
      pkt[10] = 8'd0;
      pkt[11] = 8'd0;
      n = 13;
    end else begin
      pkt[3] = TRQ_LEN;
      pkt[4] = WRITE_INSTR;
      pkt[5] = TRQ_REG;
      pkt[6] = {7'd0, en};
      n = 8;
    end
    // checksum over id up to the byte before it
    sum = 8'd0;
    for (int i = 2; i < n - 1; i++) sum = sum + pkt[i];
    for (int i = 0; i < n - 1; i++) begin
      b.tx_byte   = pkt[i];
      b.last_byte = 1'b0;
      expected_bytes.push_back(b);
    end
    b.tx_byte   = ~sum;
    b.last_byte = 1'b1;
    expected_bytes.push_back(b);
  endfunction

  // send one command transaction, holding it until accepted
  task automatic send_command(input logic f, input logic [7:0] id,
                              input logic signed [15:0] pos,
                              input logic [15:0] ms, input logic en);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    servo_id_i  <= id;
    position_i  <= pos;
    move_time_i <= ms;
    torque_on_i <= en;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    build_write_packet(f, id, pos, ms, en);
    if (f == FUNC_POSITION) pos_cmds_sent++;
    else trq_cmds_sent++;
  endtask

  // random command, biased toward the clamp boundaries
  task automatic send_random_command();
    logic [7:0]         id;
    logic signed [15:0] pos;
    int                 edge_val;
    if ($urandom_range(0, 2) == 0) id = 8'($urandom_range(0, 255));
    else id = 8'($urandom_range(0, 9));
    case ($urandom_range(0, 3))
      0: pos = 16'($urandom());
      1: pos = 16'($urandom_range(0, 1100));
      2: begin
        if (id < NUM_LIMITED) begin
          edge_val = $urandom_range(0, 1) ? window_min(id[2:0]) : window_max(id[2:0]);
        end else begin
          edge_val = $urandom_range(0, 1) ? 0 : 1023;
        end
        pos = 16'(edge_val + int'($urandom_range(0, 4)) - 2);
      end
      default: pos = 16'(-int'($urandom_range(1, 40)));
    endcase
    send_command(1'($urandom_range(0, 1)), id, pos, 16'($urandom()),
                 1'($urandom_range(0, 1)));
  endtask

  // stop sending until the last expected byte is out
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() > 0) @(posedge clk_i);
  endtask

  // boundary positions, every servo window, both commands, unused fields
  task automatic test_directed();
    send_command(FUNC_POSITION, 8'd0, -16'sd32768, 16'h0000, 1'b0);
    send_command(FUNC_POSITION, 8'd0, 16'sd32767, 16'hFFFF, 1'b1);
    send_command(FUNC_POSITION, 8'd1, 16'sd600, 16'h1234, 1'b0);
    send_command(FUNC_POSITION, 8'd2, 16'sd790, 16'h00FF, 1'b0);
    send_command(FUNC_POSITION, 8'd2, 16'sd992, 16'hFF00, 1'b0);
    send_command(FUNC_POSITION, 8'd3, 16'sd36, 16'h8000, 1'b0);
    send_command(FUNC_POSITION, 8'd3, 16'sd237, 16'h0001, 1'b0);
    send_command(FUNC_POSITION, 8'd4, 16'sd400, 16'h03E8, 1'b0);
    send_command(FUNC_POSITION, 8'd5, 16'sd0, 16'h0064, 1'b0);
    send_command(FUNC_POSITION, 8'd6, 16'sd1023, 16'h7FFF, 1'b0);
    send_command(FUNC_POSITION, 8'd6, 16'sd820, 16'h0200, 1'b0);
    send_command(FUNC_POSITION, 8'd7, 16'sd265, 16'h0010, 1'b0);
    send_command(FUNC_POSITION, 8'd7, -16'sd1, 16'h0010, 1'b1);
    send_command(FUNC_POSITION, 8'd8, -16'sd1, 16'h0000, 1'b0);
    send_command(FUNC_POSITION, 8'd8, 16'sd0, 16'h0000, 1'b0);
    send_command(FUNC_POSITION, 8'd8, 16'sd1023, 16'hFFFF, 1'b0);
    send_command(FUNC_POSITION, 8'd8, 16'sd1024, 16'hFFFF, 1'b0);
    send_command(FUNC_POSITION, 8'hFE, 16'sd512, 16'hA55A, 1'b1);
    send_command(FUNC_POSITION, 8'hFF, 16'sd32767, 16'hFFFF, 1'b1);
    send_command(FUNC_TORQUE, 8'd0, -16'sd32768, 16'hFFFF, 1'b1);
    send_command(FUNC_TORQUE, 8'd0, 16'sd0, 16'h0000, 1'b0);
    send_command(FUNC_TORQUE, 8'hFF, 16'sd32767, 16'hFFFF, 1'b1);
    send_command(FUNC_TORQUE, 8'hFE, 16'sd1000, 16'h1234, 1'b0);
    send_command(FUNC_TORQUE, 8'd7, -16'sd1, 16'h5A5A, 1'b1);
  endtask

  // random commands with idling on both sides
  task automatic test_random_commands();
    repeat (150) send_random_command();
  endtask

  // short bursts, each followed by a full drain of the output
  task automatic test_drain_pause();
    repeat (3) begin
      repeat (4) send_random_command();
      wait_until_drained();
    end
  endtask

  // back-to-back packets with no idling at all
  task automatic test_back_to_back();
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    repeat (45) send_random_command();
  endtask

  // receiver: random stall bursts and byte check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected byte %02h last %0b", tx_byte_o, last_byte_o);
        end
      end else begin
        if (tx_byte_o !== expected_bytes[0].tx_byte ||
            last_byte_o !== expected_bytes[0].last_byte) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("byte %0d: expected %02h last %0b, got %02h last %0b", bytes_checked,
                     expected_bytes[0].tx_byte, expected_bytes[0].last_byte,
                     tx_byte_o, last_byte_o);
          end
        end
        void'(expected_bytes.pop_front());
        bytes_checked++;
      end
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // main sequence
  initial begin
    mismatch_count  = 0;
    bytes_checked   = 0;
    pos_cmds_sent   = 0;
    trq_cmds_sent   = 0;
    cycle_count     = 0;
    stall_left      = 0;
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    func_i      <= FUNC_POSITION;
    servo_id_i  <= 8'd0;
    position_i  <= 16'sd0;
    move_time_i <= 16'd0;
    torque_on_i <= 1'b0;
    out_stall_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_commands();
    test_drain_pause();
    test_back_to_back();

    wait_until_drained();
    repeat (20) @(posedge clk_i);

    $display("sent %0d position and %0d torque commands, checked %0d packet bytes",
             pos_cmds_sent, trq_cmds_sent, bytes_checked);
    $display("%0d mismatches over clamping, checksum and handshake idling", mismatch_count);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/scfb_pkg.sv
src/scfb_frame_build.sv
src/scfb_serializer.sv
src/servo_command_frame_builder_core.sv
verif/servo_command_frame_builder_core_test.sv
